/* rtl/rmsp_pkg.sv */
`default_nettype none
package rmsp_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [1:0] CSR_DECAY         = 2'd1;
   localparam logic [1:0] CSR_EPSILON       = 2'd2;
   localparam logic [1:0] CSR_CENTERED      = 2'd3;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic signed [63:0] MAX32 = 64'sd2147483647;
   localparam logic signed [63:0] MIN32 = -64'sd2147483648;
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   // shared unit operations
   typedef enum logic [2:0] {
      OP_MUL  = 3'd0,
      OP_SQRT = 3'd1,
      OP_DIV  = 3'd2
   } op_type;

   typedef struct packed {
      logic        start;
      op_type      op;
      logic [63:0] opa;
      logic [63:0] opb;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } alu_rsp_type;

   function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
      if (v > MAX32) return MAX32;
      if (v < MIN32) return MIN32;
      return v;
   endfunction

endpackage
`default_nettype wire

/* rtl/rmsprop_linear_regression_step.sv */
`default_nettype none
// RMSProp training step for a one-feature linear regression. Each accepted sample
// (feature, target) returns one result: the loss from the old weight and bias, then
// the updated weight and bias, all Q8.24 and saturated. A new sample is not accepted
// until the result of the last one has been taken. A small sequencer runs every
// multiply, both square roots and both divisions through one shared arithmetic
// unit. The result is held while rsp_stall is high. req_stall stays high from
// acceptance until the result has been transferred. Configuration is written
// through csr_* while no sample is in flight.
module rmsprop_linear_regression_step #(
   parameter int FRAC_BITS = 24
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire signed [31:0] req_feature,
   input  wire signed [31:0] req_target,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [30:0]       rsp_loss,
   output logic signed [31:0] rsp_new_weight,
   output logic signed [31:0] rsp_new_bias,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire [rmsp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire [rmsp_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   typedef enum logic [24:0] {
      S_IDLE    = 25'd1 << 0,
      S_WX      = 25'd1 << 1,   // d, start d*d
      S_D       = 25'd1 << 2,   // loss, start d*x
      S_LOSS    = 25'd1 << 3,   // gradients, start g*g
      S_GRAD    = 25'd1 << 4,   // bias pass, start g*g
      S_G2      = 25'd1 << 5,   // start a*sq
      S_BSQ1    = 25'd1 << 6,   // start (1-a)*g2
      S_BSQ2    = 25'd1 << 7,   // new sq, start a*mean
      S_BMN1    = 25'd1 << 8,   // start (1-a)*g
      S_BMN2    = 25'd1 << 9,   // new mean, start mean*mean
      S_MM      = 25'd1 << 10,  // radicand, start sqrt
      S_SQRT    = 25'd1 << 11,  // denom, start lr*g
      S_NUM     = 25'd1 << 12,  // numerator, start divide
      S_DIV     = 25'd1 << 13,  // apply step
      S_OUT     = 25'd1 << 14
   } state_type;

   localparam logic [63:0] HALF_Q = 64'd1 << (FRAC_BITS - 1);

   state_type state_ff, state_in;

   logic [24:0] lr_ff, lr_in;
   logic [16:0] decay_ff, decay_in;
   logic [24:0] eps_ff, eps_in;
   logic        cent_ff, cent_in;

   logic signed [31:0] weight_ff, weight_in, bias_ff, bias_in;
   logic signed [31:0] sqw_ff, sqw_in, sqb_ff, sqb_in;
   logic signed [31:0] mnw_ff, mnw_in, mnb_ff, mnb_in;

   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] d_ff, d_in;
   logic signed [31:0] gw_ff, gw_in, gb_ff, gb_in;
   logic signed [31:0] g_ff, g_in;       // gradient of current parameter
   logic signed [31:0] g2_ff, g2_in;
   logic signed [63:0] t_ff, t_in;       // blend partial sum / radicand
   logic [63:0]        den_ff, den_in;
   logic signed [63:0] num_ff, num_in;
   logic               sel_ff, sel_in;   // 0 weight, 1 bias
   logic [30:0]        loss_ff, loss_in;
   logic               rsp_valid_ff, rsp_valid_in;

   rmsp_pkg::alu_req_type alu_req;
   rmsp_pkg::alu_rsp_type alu_rsp;

   rmsp_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   logic [16:0]        a_eff;
   logic signed [63:0] prod, mulq_res, blend_res, step_mag, par_new;
   logic signed [31:0] sq_cur, mn_cur, par_cur;
   logic signed [63:0] sum_d;

   always_comb begin
      a_eff    = (decay_ff > rmsp_pkg::ONE_Q16) ? rmsp_pkg::ONE_Q16 : decay_ff;
      prod     = $signed(alu_rsp.result);
      mulq_res = (prod + $signed(HALF_Q)) >>> FRAC_BITS;
      blend_res = rmsp_pkg::sat32((t_ff + prod + 64'sd32768) >>> 16);
      sq_cur   = sel_ff ? sqb_ff : sqw_ff;
      mn_cur   = sel_ff ? mnb_ff : mnw_ff;
      par_cur  = sel_ff ? bias_ff : weight_ff;
      sum_d    = 64'(mulq_res) + 64'(bias_ff) - 64'(y_ff);
      // divide result clamped to 2^31, also used when the denominator is zero
      if (den_ff == 64'd0 || alu_rsp.result > 64'h8000_0000)
         step_mag = 64'sh8000_0000;
      else
         step_mag = $signed(alu_rsp.result);
      if (num_ff < 0)
         par_new = rmsp_pkg::sat32(64'(par_cur) + step_mag);
      else
         par_new = rmsp_pkg::sat32(64'(par_cur) - step_mag);
   end

   always_comb begin
      state_in = state_ff;
      lr_in = lr_ff; decay_in = decay_ff; eps_in = eps_ff; cent_in = cent_ff;
      weight_in = weight_ff; bias_in = bias_ff;
      sqw_in = sqw_ff; sqb_in = sqb_ff; mnw_in = mnw_ff; mnb_in = mnb_ff;
      x_in = x_ff; y_in = y_ff; d_in = d_ff; gw_in = gw_ff; gb_in = gb_ff;
      g_in = g_ff; g2_in = g2_ff; t_in = t_ff; den_in = den_ff; num_in = num_ff;
      sel_in = sel_ff; loss_in = loss_ff;
      rsp_valid_in = rsp_valid_ff;
      alu_req.start = 1'b0;
      alu_req.op    = rmsp_pkg::OP_MUL;
      alu_req.opa   = '0;
      alu_req.opb   = '0;

      // take configuration writes; unknown indexes drop
      if (csr_valid && csr_ready) begin
         case (csr_index)
            3'(rmsp_pkg::CSR_LEARNING_RATE): lr_in    = csr_data[24:0];
            3'(rmsp_pkg::CSR_DECAY):         decay_in = csr_data[16:0];
            3'(rmsp_pkg::CSR_EPSILON):       eps_in   = csr_data[24:0];
            3'(rmsp_pkg::CSR_CENTERED):      cent_in  = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in = req_feature;
               y_in = req_target;
               alu_req = '{1'b1, rmsp_pkg::OP_MUL, 64'(weight_ff), 64'(req_feature)};
               state_in = S_WX;
            end
         end
         S_WX: if (alu_rsp.done) begin
            d_in = 32'(rmsp_pkg::sat32(sum_d));
            alu_req = '{1'b1, rmsp_pkg::OP_MUL, 64'(d_in), 64'(d_in)};
            state_in = S_D;
         end
         S_D: if (alu_rsp.done) begin
            loss_in = (mulq_res > rmsp_pkg::MAX32) ? 31'h7fff_ffff : mulq_res[30:0];
            alu_req = '{1'b1, rmsp_pkg::OP_MUL, 64'(d_ff), 64'(x_ff)};
            state_in = S_LOSS;
         end
         S_LOSS: if (alu_rsp.done) begin
            gw_in = 32'(rmsp_pkg::sat32(mulq_res <<< 1));
            gb_in = 32'(rmsp_pkg::sat32(64'(d_ff) <<< 1));
            g_in  = gw_in;
            sel_in = 1'b0;
            alu_req = '{1'b1, rmsp_pkg::OP_MUL, 64'(gw_in), 64'(gw_in)};
            state_in = S_G2;
         end
         S_GRAD: begin
            // start second parameter
            g_in = gb_ff;
            sel_in = 1'b1;
            alu_req = '{1'b1, rmsp_pkg::OP_MUL, 64'(gb_ff), 64'(gb_ff)};
            state_in = S_G2;
         end
         S_G2: if (alu_rsp.done) begin
            g2_in = (mulq_res > rmsp_pkg::MAX32) ? 32'h7fff_ffff : mulq_res[31:0];
            alu_req = '{1'b1, rmsp_pkg::OP_MUL, 64'(a_eff), 64'(sq_cur)};
            state_in = S_BSQ1;
         end
         S_BSQ1: if (alu_rsp.done) begin
            t_in = prod;
            alu_req = '{1'b1, rmsp_pkg::OP_MUL, 64'(rmsp_pkg::ONE_Q16 - a_eff), 64'(g2_ff)};
            state_in = S_BSQ2;
         end
         S_BSQ2: if (alu_rsp.done) begin
            if (sel_ff) sqb_in = blend_res[31:0]; else sqw_in = blend_res[31:0];
            t_in = blend_res + 64'(eps_ff);
            if (cent_ff) begin
               alu_req = '{1'b1, rmsp_pkg::OP_MUL, 64'(a_eff), 64'(mn_cur)};
               state_in = S_BMN1;
            end else begin
               state_in = S_MM;
            end
         end
         S_BMN1: if (alu_rsp.done) begin
            num_in = prod;  // hold a*mean
            alu_req = '{1'b1, rmsp_pkg::OP_MUL, 64'(rmsp_pkg::ONE_Q16 - a_eff), 64'(g_ff)};
            state_in = S_BMN2;
         end
         S_BMN2: if (alu_rsp.done) begin
            g2_in = 32'(rmsp_pkg::sat32((num_ff + prod + 64'sd32768) >>> 16));
            if (sel_ff) mnb_in = g2_in; else mnw_in = g2_in;
            alu_req = '{1'b1, rmsp_pkg::OP_MUL, 64'(g2_in), 64'(g2_in)};
            state_in = S_MM;
         end
         S_MM: begin
            if (!cent_ff || alu_rsp.done) begin
               if (cent_ff) t_in = t_ff - mulq_res;
               else         t_in = t_ff;
               if (t_in < 0) t_in = '0;
               alu_req = '{1'b1, rmsp_pkg::OP_SQRT, 64'(t_in) << FRAC_BITS, 64'd0};
               state_in = S_SQRT;
            end
         end
         S_SQRT: if (alu_rsp.done) begin
            den_in = alu_rsp.result;
            alu_req = '{1'b1, rmsp_pkg::OP_MUL, 64'(lr_ff), 64'(g_ff)};
            state_in = S_NUM;
         end
         S_NUM: if (alu_rsp.done) begin
            num_in = prod;
            alu_req = '{1'b1, rmsp_pkg::OP_DIV,
                        (prod < 0) ? 64'(-prod) : 64'(prod), den_ff};
            state_in = S_DIV;
         end
         S_DIV: if (alu_rsp.done) begin
            if (num_ff != 0) begin
               if (sel_ff) bias_in = par_new[31:0]; else weight_in = par_new[31:0];
            end
            if (sel_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_GRAD;
            end
         end
         S_OUT: begin
            // hold result until transfer
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lr_ff <= 25'd167772; decay_ff <= 17'd64880; eps_ff <= 25'd17; cent_ff <= 1'b0;
         weight_ff <= '0; bias_ff <= '0; sqw_ff <= '0; sqb_ff <= '0;
         mnw_ff <= '0; mnb_ff <= '0;
         rsp_valid_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lr_ff <= lr_in; decay_ff <= decay_in; eps_ff <= eps_in; cent_ff <= cent_in;
         weight_ff <= weight_in; bias_ff <= bias_in; sqw_ff <= sqw_in; sqb_ff <= sqb_in;
         mnw_ff <= mnw_in; mnb_ff <= mnb_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff <= sel_in;
      end
      x_ff <= x_in; y_ff <= y_in; d_ff <= d_in; gw_ff <= gw_in; gb_ff <= gb_in;
      g_ff <= g_in; g2_ff <= g2_in; t_ff <= t_in; den_ff <= den_in; num_ff <= num_in;
      loss_ff <= loss_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign csr_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_loss       = loss_ff;
   assign rsp_new_weight = weight_ff;
   assign rsp_new_bias   = bias_ff;

   a_valid_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == S_OUT)) else $error("rsp_valid out of step");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall) else $error("input open while result pending");
   a_weights_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> $stable(weight_ff) && $stable(bias_ff))
      else $error("parameters moved after result");

endmodule
`default_nettype wire

/* rtl/rmsp_alu.sv */
`default_nettype none
// Shared multi-cycle unit: 32x32 signed multiply in two 32x16 partial products,
// 64-bit bit-serial integer square root and 64/64 bit-serial unsigned divide.
module rmsp_alu (
   input  wire                    clock,
   input  wire                    reset,
   input  rmsp_pkg::alu_req_type  req,
   output rmsp_pkg::alu_rsp_type  rsp
);

   typedef enum logic [3:0] {
      AS_IDLE = 4'b0001,
      AS_MUL  = 4'b0010,
      AS_SQRT = 4'b0100,
      AS_DIV  = 4'b1000
   } alu_state_type;

   alu_state_type state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [64:0] rem_ff, rem_in;
   logic        done_ff, done_in;

   logic signed [48:0] pp;
   logic [64:0] rem_shift, rem_try;
   logic [65:0] sq_try;
   logic [65:0] sq_rem_shift;

   always_comb begin
      // partial product of signed a by one 16-bit half of b
      if (cnt_ff[0] == 1'b0)
         pp = $signed(a_ff[31:0]) * $signed({1'b0, b_ff[15:0]});
      else
         pp = $signed(a_ff[31:0]) * $signed(b_ff[31:16]);
      rem_shift    = {rem_ff[63:0], a_ff[63]};
      rem_try      = rem_shift - {1'b0, b_ff};
      sq_rem_shift = {rem_ff[63:0], a_ff[63:62]};
      sq_try       = sq_rem_shift - {acc_ff, 2'b01};
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      case (state_ff)
         AS_IDLE: begin
            if (req.start) begin
               a_in   = req.opa;
               b_in   = req.opb;
               acc_in = '0;
               rem_in = '0;
               cnt_in = '0;
               case (req.op)
                  rmsp_pkg::OP_MUL:  state_in = AS_MUL;
                  rmsp_pkg::OP_SQRT: state_in = AS_SQRT;
                  rmsp_pkg::OP_DIV:  state_in = AS_DIV;
                  default:           state_in = AS_MUL;
               endcase
            end
         end
         AS_MUL: begin
            // accumulate low then high partial product
            if (cnt_ff[0] == 1'b0) begin
               acc_in = 64'(pp);
               cnt_in = 6'd1;
            end else begin
               acc_in   = acc_ff + {pp[47:0], 16'd0};
               done_in  = 1'b1;
               state_in = AS_IDLE;
            end
         end
         AS_SQRT: begin
            // one result bit per cycle, two radicand bits consumed
            if (!sq_try[65]) begin
               rem_in = sq_try[64:0];
               acc_in = {acc_ff[62:0], 1'b1};
            end else begin
               rem_in = sq_rem_shift[64:0];
               acc_in = {acc_ff[62:0], 1'b0};
            end
            a_in   = {a_ff[61:0], 2'b00};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               done_in  = 1'b1;
               state_in = AS_IDLE;
            end
         end
         AS_DIV: begin
            // restoring division, one quotient bit per cycle
            if (!rem_try[64]) begin
               rem_in = rem_try;
               acc_in = {acc_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               acc_in = {acc_ff[62:0], 1'b0};
            end
            a_in   = {a_ff[62:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               done_in  = 1'b1;
               state_in = AS_IDLE;
            end
         end
         default: state_in = AS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AS_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = acc_ff;

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("alu done held two cycles");
   a_idle_after_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == AS_IDLE) else $error("alu busy at done");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != AS_IDLE) |-> !done_ff) else $error("alu done while busy");

endmodule
`default_nettype wire
